@@ rtl/ccd_gain_dark_flat_correction_defines.svh @@
// Assertion macros for the checker file of the pixel correction block.
`ifndef CCD_GAIN_DARK_FLAT_CORRECTION_DEFINES_SVH
`define CCD_GAIN_DARK_FLAT_CORRECTION_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define CCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define CCD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: reset check failed");

`endif

@@ rtl/ccd_pkg.sv @@
`default_nettype none

package ccd_pkg;

    localparam int POS_W     = 20;
    localparam int WORD_W    = 16;
    localparam int TVAL_W    = 20;
    localparam int GAIN_W    = 12;
    localparam int FLAT_W    = 16;
    localparam int RES_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Item kinds; the first three equal the func codes on the input port.
    typedef enum logic [1:0] {
        OP_LOAD_BG   = 2'd0,
        OP_LOAD_FLAT = 2'd1,
        OP_PIXEL     = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAD_MASK      = 3'd0,
        CFG_GAIN_ONE_MASK = 3'd1,
        CFG_GAIN_TWO_MASK = 3'd2,
        CFG_COUNT_MASK    = 3'd3,
        CFG_GAIN_FINE     = 3'd4,
        CFG_GAIN_MEDIUM   = 3'd5,
        CFG_GAIN_COARSE   = 3'd6
    } t_cfg_idx;

    localparam logic [1:0] STAGE_FINE   = 2'd0;
    localparam logic [1:0] STAGE_MEDIUM = 2'd1;
    localparam logic [1:0] STAGE_COARSE = 2'd2;
    localparam logic [1:0] STAGE_NONE   = 2'd3;

    localparam logic [WORD_W-1:0] RST_BAD_MASK      = 16'd8192;
    localparam logic [WORD_W-1:0] RST_GAIN_ONE_MASK = 16'd49152;
    localparam logic [WORD_W-1:0] RST_GAIN_TWO_MASK = 16'd16384;
    localparam logic [WORD_W-1:0] RST_COUNT_MASK    = 16'd8191;
    localparam logic [GAIN_W-1:0] RST_GAIN_FINE     = 12'd256;
    localparam logic [GAIN_W-1:0] RST_GAIN_MEDIUM   = 12'd512;
    localparam logic [GAIN_W-1:0] RST_GAIN_COARSE   = 12'd2048;

    localparam logic signed [TVAL_W-1:0] FLAT_MAX = 20'sd65535;

    // Everything an item carries down the pipeline besides its position.
    typedef struct packed {
        t_op                      op;
        logic [1:0]               tstage;
        logic signed [TVAL_W-1:0] tval;
        logic                     bad;
        logic [1:0]               gstage;
        logic [GAIN_W-1:0]        gain;
        logic [WORD_W-1:0]        count;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/ccd_pos_wrap.sv @@
`default_nettype none

// Reduces the pixel position modulo the image size in three stages:
// reciprocal multiply, back multiply, then subtract with one correction.
module ccd_pos_wrap #(
    parameter int IMAGE_PIXELS = 1048576,
    localparam int ADDR_W = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_en,
    input  wire                       i_vld,
    input  wire ccd_pkg::t_item       i_item,
    input  wire [ccd_pkg::POS_W-1:0]  i_pos,
    output logic                      o_vld,
    output ccd_pkg::t_item            o_item,
    output logic [ADDR_W-1:0]         o_addr
);

    localparam int POS_W   = ccd_pkg::POS_W;
    localparam int NB      = $clog2(IMAGE_PIXELS);
    localparam int SHIFT   = POS_W + NB;
    localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / 64'(IMAGE_PIXELS);
    localparam int RECIP_W = POS_W + 2;
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
    localparam int PROD_W  = POS_W + RECIP_W;
    localparam logic [31:0] DEPTH = 32'(IMAGE_PIXELS);

    logic                 r_vld1, r_vld2, r_vld3;
    ccd_pkg::t_item       r_item1, r_item2, r_item3;
    logic [POS_W-1:0]     r_pos1, r_pos2;
    logic [PROD_W-1:0]    r_prod1;
    logic [POS_W-1:0]     r_qn2;
    logic [ADDR_W-1:0]    r_addr3;

    logic [POS_W-1:0]     w_quot;
    logic [POS_W-1:0]     w_rem;
    logic [POS_W-1:0]     w_wrap;

    // The quotient estimate is the true quotient or one below it.
    assign w_quot = POS_W'(r_prod1 >> SHIFT);
    assign w_rem  = r_pos2 - r_qn2;
    assign w_wrap = (32'(w_rem) >= DEPTH) ? (w_rem - POS_W'(DEPTH)) : w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item1 <= i_item;
            r_pos1  <= i_pos;
            r_prod1 <= PROD_W'(i_pos) * PROD_W'(RECIP);
            r_item2 <= r_item1;
            r_pos2  <= r_pos1;
            r_qn2   <= POS_W'(32'(w_quot) * DEPTH);
            r_item3 <= r_item2;
            r_addr3 <= ADDR_W'(w_wrap);
        end
    end

    assign o_vld  = r_vld3;
    assign o_item = r_item3;
    assign o_addr = r_addr3;

endmodule

`default_nettype wire

@@ rtl/ccd_tables.sv @@
`default_nettype none

// Background and flat-field stores. Loads write and pixels read in the same
// stage, so table updates and reads keep item order.
module ccd_tables #(
    parameter int IMAGE_PIXELS = 1048576,
    localparam int ADDR_W = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_en,
    input  wire                                   i_vld,
    input  wire ccd_pkg::t_item                   i_item,
    input  wire [ADDR_W-1:0]                      i_addr,
    output logic                                  o_vld,
    output ccd_pkg::t_item                        o_item,
    output logic signed [ccd_pkg::TVAL_W-1:0]     o_bg,
    output logic [ccd_pkg::FLAT_W-1:0]            o_flat
);

    logic signed [ccd_pkg::TVAL_W-1:0] r_bg_mem [3][IMAGE_PIXELS];
    logic [ccd_pkg::FLAT_W-1:0]        r_flat_mem [IMAGE_PIXELS];

    logic                              r_vld;
    ccd_pkg::t_item                    r_item;
    logic signed [ccd_pkg::TVAL_W-1:0] r_bg_rd;
    logic [ccd_pkg::FLAT_W-1:0]        r_flat_rd;

    always_ff @(posedge i_clk) begin
        if (i_en && i_vld) begin
            if (i_item.op == ccd_pkg::OP_LOAD_BG) begin
                r_bg_mem[i_item.tstage][i_addr] <= i_item.tval;
            end
            if (i_item.op == ccd_pkg::OP_LOAD_FLAT) begin
                r_flat_mem[i_addr] <= i_item.tval[ccd_pkg::FLAT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bg_rd   <= r_bg_mem[i_item.gstage][i_addr];
            r_flat_rd <= r_flat_mem[i_addr];
            r_item    <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
    assign o_bg   = r_bg_rd;
    assign o_flat = r_flat_rd;

endmodule

`default_nettype wire

@@ rtl/ccd_scale.sv @@
`default_nettype none

// Arithmetic tail: difference and flat-gain product, full product,
// magnitude, then rounding into the output register.
module ccd_scale (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_en,
    input  wire                                   i_vld,
    input  wire ccd_pkg::t_item                   i_item,
    input  wire signed [ccd_pkg::TVAL_W-1:0]      i_bg,
    input  wire [ccd_pkg::FLAT_W-1:0]             i_flat,
    output logic                                  o_vld,
    output logic signed [ccd_pkg::RES_W-1:0]      o_value,
    output logic                                  o_bad,
    output logic [1:0]                            o_stage
);

    localparam int DIFF_W = ccd_pkg::TVAL_W + 2;
    localparam int FG_W   = ccd_pkg::FLAT_W + ccd_pkg::GAIN_W;
    localparam int PROD_W = FG_W + 1 + DIFF_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int FRAC_DROP = 22;
    localparam int RND_W  = MAG_W - FRAC_DROP;

    logic                      r_vld5, r_vld6, r_vld7, r_vld8;
    logic                      r_bad5, r_bad6, r_bad7, r_bad8;
    logic [1:0]                r_stg5, r_stg6, r_stg7, r_stg8;
    logic signed [DIFF_W-1:0]  r_diff5;
    logic [FG_W-1:0]           r_fg5;
    logic signed [PROD_W-1:0]  r_prod6;
    logic                      r_neg7;
    logic [MAG_W-1:0]          r_mag7;
    logic signed [ccd_pkg::RES_W-1:0] r_value8;

    logic signed [DIFF_W-1:0]  w_count_s;
    logic signed [DIFF_W-1:0]  w_bg_s;
    logic signed [PROD_W-1:0]  w_fg_s;
    logic signed [PROD_W-1:0]  w_diff_s;
    logic [PROD_W-1:0]         w_abs;
    logic [RND_W-1:0]          w_round;
    logic [ccd_pkg::RES_W-1:0] w_mag32;
    logic [ccd_pkg::RES_W-1:0] w_value;

    assign w_count_s = $signed({2'b00, i_item.count, 4'b0000});
    assign w_bg_s    = DIFF_W'(i_bg);
    assign w_fg_s    = $signed(PROD_W'(r_fg5));
    assign w_diff_s  = PROD_W'(r_diff5);
    assign w_abs     = r_prod6[PROD_W-1] ? (~r_prod6 + PROD_W'(1)) : r_prod6;

    // Round to nearest with ties away from zero on the magnitude. The largest
    // possible magnitude stays far below the 32-bit limit, so no clamp.
    assign w_round = RND_W'((r_mag7 + MAG_W'(1 << (FRAC_DROP - 1))) >> FRAC_DROP);
    assign w_mag32 = ccd_pkg::RES_W'(w_round);
    assign w_value = r_neg7 ? (~w_mag32 + ccd_pkg::RES_W'(1)) : w_mag32;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
            r_vld7 <= 1'b0;
            r_vld8 <= 1'b0;
        end else if (i_en) begin
            r_vld5 <= i_vld && (i_item.op == ccd_pkg::OP_PIXEL);
            r_vld6 <= r_vld5;
            r_vld7 <= r_vld6;
            r_vld8 <= r_vld7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bad5   <= i_item.bad;
            r_stg5   <= i_item.gstage;
            r_diff5  <= w_count_s - w_bg_s;
            r_fg5    <= FG_W'(i_flat) * FG_W'(i_item.gain);

            r_bad6   <= r_bad5;
            r_stg6   <= r_stg5;
            r_prod6  <= w_fg_s * w_diff_s;

            r_bad7   <= r_bad6;
            r_stg7   <= r_stg6;
            r_neg7   <= r_prod6[PROD_W-1];
            r_mag7   <= w_abs[MAG_W-1:0];

            r_bad8   <= r_bad7;
            r_stg8   <= r_bad7 ? ccd_pkg::STAGE_FINE : r_stg7;
            r_value8 <= r_bad7 ? '0 : $signed(w_value);
        end
    end

    assign o_vld   = r_vld8;
    assign o_value = r_value8;
    assign o_bad   = r_bad8;
    assign o_stage = r_stg8;

endmodule

`default_nettype wire

@@ rtl/ccd_gain_dark_flat_correction.sv @@
// Throughput: one item per cycle; one common enable moves all stages, and a
// held result on the output stalls the whole pipeline until it is taken.
// Reset (synchronous, active low) clears every valid bit and loads the
// configuration defaults; the table memories are not cleared.
`default_nettype none

module ccd_gain_dark_flat_correction #(
    parameter int IMAGE_PIXELS = 1048576
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,

    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire [1:0]                             i_func,
    input  wire [ccd_pkg::WORD_W-1:0]             i_pixel_word,
    input  wire [ccd_pkg::POS_W-1:0]              i_pixel_position,
    input  wire [1:0]                             i_table_stage,
    input  wire signed [ccd_pkg::TVAL_W-1:0]      i_table_value,

    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic signed [ccd_pkg::RES_W-1:0]      o_corrected_value,
    output logic                                  o_bad_pixel,
    output logic [1:0]                            o_gain_stage,

    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [ccd_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [ccd_pkg::WORD_W-1:0]             i_cfg_data
);

    localparam int ADDR_W = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1;

    // Configuration registers. Writes are to be made only while the pipeline is
    // empty, which the block itself does not enforce; they are taken in every cycle.
    logic [ccd_pkg::WORD_W-1:0] r_bad_mask;
    logic [ccd_pkg::WORD_W-1:0] r_gain_one_mask;
    logic [ccd_pkg::WORD_W-1:0] r_gain_two_mask;
    logic [ccd_pkg::WORD_W-1:0] r_count_mask;
    logic [ccd_pkg::GAIN_W-1:0] r_gain_fine;
    logic [ccd_pkg::GAIN_W-1:0] r_gain_medium;
    logic [ccd_pkg::GAIN_W-1:0] r_gain_coarse;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad_mask      <= ccd_pkg::RST_BAD_MASK;
            r_gain_one_mask <= ccd_pkg::RST_GAIN_ONE_MASK;
            r_gain_two_mask <= ccd_pkg::RST_GAIN_TWO_MASK;
            r_count_mask    <= ccd_pkg::RST_COUNT_MASK;
            r_gain_fine     <= ccd_pkg::RST_GAIN_FINE;
            r_gain_medium   <= ccd_pkg::RST_GAIN_MEDIUM;
            r_gain_coarse   <= ccd_pkg::RST_GAIN_COARSE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ccd_pkg::CFG_BAD_MASK:      r_bad_mask      <= i_cfg_data;
                ccd_pkg::CFG_GAIN_ONE_MASK: r_gain_one_mask <= i_cfg_data;
                ccd_pkg::CFG_GAIN_TWO_MASK: r_gain_two_mask <= i_cfg_data;
                ccd_pkg::CFG_COUNT_MASK:    r_count_mask    <= i_cfg_data;
                ccd_pkg::CFG_GAIN_FINE:     r_gain_fine     <= i_cfg_data[ccd_pkg::GAIN_W-1:0];
                ccd_pkg::CFG_GAIN_MEDIUM:   r_gain_medium   <= i_cfg_data[ccd_pkg::GAIN_W-1:0];
                ccd_pkg::CFG_GAIN_COARSE:   r_gain_coarse   <= i_cfg_data[ccd_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is empty or its
    // result is being transferred. All stages share this enable, so a stall
    // freezes every item in place and nothing is lost or repeated.
    logic w_en;
    logic w_out_vld;

    assign w_en    = !w_out_vld || i_ready;
    assign o_ready = w_en;

    // Decode the incoming item. A background load to the unused fourth stage
    // and the unused function code both become empty items. Flat values are
    // clamped into the unsigned 16-bit range here, before they reach the table.
    ccd_pkg::t_item w_item;
    logic           w_bad_hit;
    logic           w_one_hit;
    logic           w_two_hit;

    assign w_bad_hit = (i_pixel_word & r_bad_mask) == r_bad_mask;
    assign w_one_hit = (i_pixel_word & r_gain_one_mask) == r_gain_one_mask;
    assign w_two_hit = (i_pixel_word & r_gain_two_mask) == r_gain_two_mask;

    always_comb begin
        w_item        = '0;
        w_item.tstage = i_table_stage;
        w_item.tval   = i_table_value;
        w_item.count  = i_pixel_word & r_count_mask;
        w_item.bad    = w_bad_hit;
        case (i_func)
            ccd_pkg::OP_LOAD_BG: begin
                w_item.op = (i_table_stage == ccd_pkg::STAGE_NONE) ?
                            ccd_pkg::OP_NONE : ccd_pkg::OP_LOAD_BG;
            end
            ccd_pkg::OP_LOAD_FLAT: begin
                w_item.op = ccd_pkg::OP_LOAD_FLAT;
                if (i_table_value < 0) begin
                    w_item.tval = '0;
                end else if (i_table_value > ccd_pkg::FLAT_MAX) begin
                    w_item.tval = ccd_pkg::FLAT_MAX;
                end
            end
            ccd_pkg::OP_PIXEL: begin
                w_item.op = ccd_pkg::OP_PIXEL;
            end
            default: begin
                w_item.op = ccd_pkg::OP_NONE;
            end
        endcase

        // Gain one is tested before gain two; neither match means the fine
        // stage. A bad pixel always reports the fine stage.
        if (w_bad_hit) begin
            w_item.gstage = ccd_pkg::STAGE_FINE;
            w_item.gain   = r_gain_fine;
        end else if (w_one_hit) begin
            w_item.gstage = ccd_pkg::STAGE_COARSE;
            w_item.gain   = r_gain_coarse;
        end else if (w_two_hit) begin
            w_item.gstage = ccd_pkg::STAGE_MEDIUM;
            w_item.gain   = r_gain_medium;
        end else begin
            w_item.gstage = ccd_pkg::STAGE_FINE;
            w_item.gain   = r_gain_fine;
        end
    end

    // Input register stage.
    logic                       r_s0_vld;
    ccd_pkg::t_item             r_s0_item;
    logic [ccd_pkg::POS_W-1:0]  r_s0_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_item <= w_item;
            r_s0_pos  <= i_pixel_position;
        end
    end

    // Position wrap: three stages.
    logic              w_pw_vld;
    ccd_pkg::t_item    w_pw_item;
    logic [ADDR_W-1:0] w_pw_addr;

    ccd_pos_wrap #(
        .IMAGE_PIXELS (IMAGE_PIXELS)
    ) u_pos_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s0_vld),
        .i_item  (r_s0_item),
        .i_pos   (r_s0_pos),
        .o_vld   (w_pw_vld),
        .o_item  (w_pw_item),
        .o_addr  (w_pw_addr)
    );

    // Table access: one stage with registered read data.
    logic                              w_tb_vld;
    ccd_pkg::t_item                    w_tb_item;
    logic signed [ccd_pkg::TVAL_W-1:0] w_tb_bg;
    logic [ccd_pkg::FLAT_W-1:0]        w_tb_flat;

    ccd_tables #(
        .IMAGE_PIXELS (IMAGE_PIXELS)
    ) u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_pw_vld),
        .i_item  (w_pw_item),
        .i_addr  (w_pw_addr),
        .o_vld   (w_tb_vld),
        .o_item  (w_tb_item),
        .o_bg    (w_tb_bg),
        .o_flat  (w_tb_flat)
    );

    // Arithmetic: four stages, the last one is the output register. Loads
    // drop out here, since they produce no result.
    ccd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_tb_vld),
        .i_item  (w_tb_item),
        .i_bg    (w_tb_bg),
        .i_flat  (w_tb_flat),
        .o_vld   (w_out_vld),
        .o_value (o_corrected_value),
        .o_bad   (o_bad_pixel),
        .o_stage (o_gain_stage)
    );

    assign o_valid = w_out_vld;

endmodule

`default_nettype wire

@@ rtl/ccd_checker.sv @@
`default_nettype none
`include "ccd_gain_dark_flat_correction_defines.svh"

module ccd_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_in_valid,
    input wire                                 i_in_ready,
    input wire                                 i_out_valid,
    input wire                                 i_out_ready,
    input wire signed [ccd_pkg::RES_W-1:0]     i_value,
    input wire                                 i_bad,
    input wire [1:0]                           i_stage
);

    // A bad pixel reports zero and the fine stage.
    `CCD_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, i_out_valid && i_bad, (i_value == '0) && (i_stage == ccd_pkg::STAGE_FINE))

    // The input side is ready exactly when the output register can move.
    `CCD_ASSERT_NOW(a_ready_follows_out, i_clk, i_rst_n, 1'b1, i_in_ready == (!i_out_valid || i_out_ready))

    // A stalled result stays in place.
    `CCD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_value) && $stable(i_bad) && $stable(i_stage))

    // Reset empties the output register.
    `CCD_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind ccd_gain_dark_flat_correction ccd_checker u_ccd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_value     (o_corrected_value),
    .i_bad       (o_bad_pixel),
    .i_stage     (o_gain_stage)
);

`default_nettype wire
